// ===== rtl/emb_pkg.sv =====
// Shared constants, types and constant functions for the Euler model matrix builder.
package emb_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int INNER_BITS       = 30;
    localparam int Z_W              = 40;

    // Arctangent of 2^-i in nano-degrees.
    localparam logic signed [Z_W-1:0] ATAN_NDEG [ATAN_ENTRIES] = '{
        40'sd45000000000, 40'sd26565051177, 40'sd14036243468, 40'sd7125016349,
        40'sd3576334375,  40'sd1789910608,  40'sd895173710,   40'sd447614171,
        40'sd223810500,   40'sd111905677,   40'sd55952892,    40'sd27976453,
        40'sd13988227,    40'sd6994114,     40'sd3497057,     40'sd1748528,
        40'sd874264,      40'sd437132,      40'sd218566,      40'sd109283,
        40'sd54642,       40'sd27321,       40'sd13660,       40'sd6830
    };

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } t_axis_rows;

    // Unsigned restoring division, used only while working out constants.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Reciprocal of the CORDIC gain in Q2.30 for a given number of steps, worked out at elaboration.
    function automatic logic [63:0] cordic_gain(input int n);
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            p = p - udiv64(p, (64'd1 << (2 * i)) + 64'd1);
        end
        rem  = p;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int q = 0; q < 32; q++) begin
            if (bitv > rem) begin
                bitv = bitv >> 2;
            end
        end
        for (int q = 0; q < 32; q++) begin
            if (bitv != 64'd0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/emb_if.sv =====
// Valid/ready channel interfaces for the input items and the result words.
interface emb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;

    modport source (output valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, output ready);
endinterface

interface emb_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, row, col, value, last, input ready);
    modport sink   (input valid, row, col, value, last, output ready);
endinterface

// ===== rtl/euler_model_matrix_builder.sv =====
// Euler-angle model matrix builder: one transaction in, sixteen Q-format matrix words out.
//
// Input channel i_in carries a position and three angles in degrees (signed fixed point
// with FRAC_BITS fraction bits). The block is ready only while idle; once a transaction is
// taken it builds M = Rz*Ry*Rx in a 16-word matrix RAM and then sends the 16 words on
// o_out in row-major order, with last set on row 3 column 3.
// All arithmetic runs through one 33x33 multiplier, one CORDIC adder set and one
// compare-subtract step under a sequencer. Per axis: 23-FRAC_BITS reduction steps (one
// from FRAC_BITS 22 up), a step to pick the angle, folding and angle scaling, CORDIC_STEPS
// CORDIC iterations (at most 24), rounding of sine and cosine, and the two mixed rows,
// built column by column. The identity load comes before the first axis and the
// translation after the last.
// Each result word is fetched from the RAM through S_OUTRD and S_OUTLD and then held on
// o_out in S_OUTW; the next word is fetched only after the current one is taken.
// The next transaction is accepted after the last word has been taken.
// A stalled receiver simply holds the current word on o_out; nothing is lost.
// Synchronous active-low reset returns the sequencer to idle; the matrix RAM is not
// cleared because every entry is written before it is read.
module euler_model_matrix_builder #(
    parameter int FRAC_BITS    = emb_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = emb_pkg::CORDIC_STEPS_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    emb_in_if.sink    i_in,
    emb_out_if.source o_out
);
    localparam int NSTEP = (CORDIC_STEPS > emb_pkg::ATAN_ENTRIES) ?
                           emb_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam int IW        = $clog2(NSTEP);
    localparam int RED_STEPS = (FRAC_BITS < 22) ? 23 - FRAC_BITS : 1;
    localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int SH        = emb_pkg::INNER_BITS - FRAC_BITS;
    localparam int ZW        = emb_pkg::Z_W;

    localparam logic signed [48:0] FULL    = 49'sd360 <<< FRAC_BITS;
    localparam logic signed [48:0] HALF    = 49'sd180 <<< FRAC_BITS;
    localparam logic signed [48:0] QUARTER = 49'sd90 <<< FRAC_BITS;
    localparam logic [47:0]        FULL_U  = 48'd360 << FRAC_BITS;
    localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] GAIN    = 34'(emb_pkg::cordic_gain(NSTEP));
    localparam logic signed [32:0] NANO    = 33'sd1000000000;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001, S_INIT  = 20'h00002, S_ANG   = 20'h00004,
        S_RED   = 20'h00008, S_FOLD  = 20'h00010, S_ZMUL  = 20'h00020,
        S_ZCONV = 20'h00040, S_CORD  = 20'h00080, S_TRIG  = 20'h00100,
        S_RDA   = 20'h00200, S_RDB   = 20'h00400, S_CAPB  = 20'h00800,
        S_MUL   = 20'h01000, S_ACC   = 20'h02000, S_WR    = 20'h04000,
        S_TRD   = 20'h08000, S_TCAP  = 20'h10000, S_OUTRD = 20'h20000,
        S_OUTLD = 20'h40000, S_OUTW  = 20'h80000
    } t_state;

    t_state                    r_state;
    logic signed [31:0]        r_pos [3];
    logic signed [31:0]        r_ang [3];
    logic [1:0]                r_axis;
    logic [1:0]                r_j;
    logic [1:0]                r_t;
    logic                      r_trans;
    logic [KW-1:0]             r_k;
    logic [IW-1:0]             r_i;
    logic [3:0]                r_cnt;
    logic [47:0]               r_rem;
    logic                      r_aneg;
    logic                      r_negcos;
    logic                      r_zneg;
    logic [31:0]               r_mag;
    logic signed [ZW-1:0]      r_z;
    logic signed [33:0]        r_x;
    logic signed [33:0]        r_y;
    logic signed [32:0]        r_c;
    logic signed [32:0]        r_s;
    logic signed [31:0]        r_ma;
    logic signed [31:0]        r_mb;
    logic signed [65:0]        r_prod;
    logic signed [67:0]        r_acc;
    logic signed [31:0]        r_oval;

    emb_pkg::t_axis_rows       rows;
    logic signed [32:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [48:0]        fold_r;
    logic                      fold_nc;
    logic signed [48:0]        fold_v;
    logic signed [65:0]        z_full;
    logic signed [33:0]        x_sh;
    logic signed [33:0]        y_sh;
    logic signed [33:0]        x_rnd;
    logic signed [33:0]        y_rnd;
    logic                      ram_we;
    logic [3:0]                ram_waddr;
    logic [31:0]               ram_wdata;
    logic [3:0]                ram_raddr;
    logic [31:0]               ram_rdata;

    function automatic logic signed [31:0] round_sat(input logic signed [67:0] acc);
        logic signed [67:0] v;
        v = (acc + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > 68'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    emb_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The two coordinates mixed by the rotation about the current axis.
    always_comb begin
        unique case (r_axis)
            2'd0:    rows = '{a: 2'd1, b: 2'd2};
            2'd1:    rows = '{a: 2'd2, b: 2'd0};
            default: rows = '{a: 2'd0, b: 2'd1};
        endcase
    end

    // Angle reduction into [-180,180) and folding into [-90,90].
    always_comb begin
        fold_r  = r_aneg ? -$signed({1'b0, r_rem}) : $signed({1'b0, r_rem});
        if (fold_r < 0) begin
            fold_r = fold_r + FULL;
        end
        if (fold_r >= HALF) begin
            fold_r = fold_r - FULL;
        end
        fold_nc = 1'b0;
        fold_v  = fold_r;
        if (fold_r > QUARTER) begin
            fold_v  = HALF - fold_r;
            fold_nc = 1'b1;
        end else if (fold_r < -QUARTER) begin
            fold_v  = -HALF - fold_r;
            fold_nc = 1'b1;
        end
    end

    always_comb begin
        z_full = (r_prod + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        x_sh   = r_x >>> r_i;
        y_sh   = r_y >>> r_i;
        x_rnd  = (r_x + (34'sd1 <<< (SH - 1))) >>> SH;
        y_rnd  = (r_y + (34'sd1 <<< (SH - 1))) >>> SH;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = 33'(r_ma);
        mul_b = 33'(r_pos[0]);
        priority if (r_state == S_ZMUL) begin
            mul_a = $signed({1'b0, r_mag});
            mul_b = NANO;
        end else if (r_trans) begin
            mul_a = 33'(r_ma);
            unique case (r_t)
                2'd1:    mul_b = 33'(r_pos[0]);
                2'd2:    mul_b = 33'(r_pos[1]);
                default: mul_b = 33'(r_pos[2]);
            endcase
        end else begin
            unique case (r_t)
                2'd0:    begin mul_a = r_c;  mul_b = 33'(r_ma); end
                2'd1:    begin mul_a = r_s;  mul_b = 33'(r_mb); end
                2'd2:    begin mul_a = -r_s; mul_b = 33'(r_ma); end
                default: begin mul_a = r_c;  mul_b = 33'(r_mb); end
            endcase
        end
    end

    // RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt;
        ram_wdata = (r_cnt[1:0] == r_cnt[3:2]) ? ONE : 32'sd0;
        ram_raddr = r_cnt;
        unique case (r_state)
            S_INIT: ram_we = 1'b1;
            S_WR: begin
                ram_we    = 1'b1;
                ram_wdata = round_sat(r_acc);
                if (r_trans) begin
                    ram_waddr = {2'd3, r_j};
                end else begin
                    ram_waddr = {(r_t == 2'd1) ? rows.a : rows.b, r_j};
                end
            end
            S_RDA: ram_raddr = {rows.a, r_j};
            S_RDB: ram_raddr = {rows.b, r_j};
            S_TRD: ram_raddr = (r_t == 2'd0) ? {2'd3, r_j} : {r_t - 2'd1, r_j};
            default: ram_raddr = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
            r_j     <= 2'd0;
            r_t     <= 2'd0;
            r_trans <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
            r_cnt   <= 4'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_pos[0] <= i_in.pos_x;
                        r_pos[1] <= i_in.pos_y;
                        r_pos[2] <= i_in.pos_z;
                        r_ang[0] <= i_in.rot_x;
                        r_ang[1] <= i_in.rot_y;
                        r_ang[2] <= i_in.rot_z;
                        r_cnt    <= 4'd0;
                        r_axis   <= 2'd0;
                        r_trans  <= 1'b0;
                        r_state  <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    // Magnitude of the angle, taken at full width so that the most negative
                    // value comes out right.
                    r_aneg  <= r_ang[r_axis][31];
                    r_rem   <= r_ang[r_axis][31] ? -{{16{1'b1}}, r_ang[r_axis]}
                                                 : {16'd0, r_ang[r_axis]};
                    r_k     <= KW'(RED_STEPS - 1);
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_rem >= (FULL_U << r_k)) begin
                        r_rem <= r_rem - (FULL_U << r_k);
                    end
                    if (r_k == '0) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_k <= r_k - 1'b1;
                    end
                end
                S_FOLD: begin
                    r_negcos <= fold_nc;
                    r_zneg   <= fold_v < 0;
                    r_mag    <= (fold_v < 0) ? 32'(-fold_v) : 32'(fold_v);
                    r_state  <= S_ZMUL;
                end
                S_ZMUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ZCONV;
                end
                S_ZCONV: begin
                    r_z     <= r_zneg ? -z_full[ZW-1:0] : z_full[ZW-1:0];
                    r_x     <= GAIN;
                    r_y     <= 34'sd0;
                    r_i     <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - y_sh;
                        r_y <= r_y + x_sh;
                        r_z <= r_z - emb_pkg::ATAN_NDEG[5'(r_i)];
                    end else begin
                        r_x <= r_x + y_sh;
                        r_y <= r_y - x_sh;
                        r_z <= r_z + emb_pkg::ATAN_NDEG[5'(r_i)];
                    end
                    if (r_i == IW'(NSTEP - 1)) begin
                        r_state <= S_TRIG;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_TRIG: begin
                    r_c     <= r_negcos ? -x_rnd[32:0] : x_rnd[32:0];
                    r_s     <= y_rnd[32:0];
                    r_j     <= 2'd0;
                    r_state <= S_RDA;
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_ma    <= ram_rdata;
                    r_state <= S_CAPB;
                end
                S_CAPB: begin
                    r_mb    <= ram_rdata;
                    r_acc   <= 68'sd0;
                    r_t     <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_acc + 68'(r_prod);
                    if (r_trans) begin
                        if (r_t == 2'd3) begin
                            r_state <= S_WR;
                        end else begin
                            r_t     <= r_t + 2'd1;
                            r_state <= S_TRD;
                        end
                    end else if (r_t == 2'd1 || r_t == 2'd3) begin
                        r_state <= S_WR;
                    end else begin
                        r_t     <= r_t + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_WR: begin
                    r_acc <= 68'sd0;
                    if (r_trans) begin
                        r_t <= 2'd0;
                        if (r_j == 2'd2) begin
                            r_cnt   <= 4'd0;
                            r_state <= S_OUTRD;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_TRD;
                        end
                    end else if (r_t == 2'd1) begin
                        r_t     <= 2'd2;
                        r_state <= S_MUL;
                    end else if (r_j != 2'd3) begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_RDA;
                    end else if (r_axis == 2'd2) begin
                        r_trans <= 1'b1;
                        r_j     <= 2'd0;
                        r_t     <= 2'd0;
                        r_state <= S_TRD;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_ANG;
                    end
                end
                S_TRD: r_state <= S_TCAP;
                S_TCAP: begin
                    if (r_t == 2'd0) begin
                        r_acc   <= 68'($signed(ram_rdata)) <<< FRAC_BITS;
                        r_t     <= 2'd1;
                        r_state <= S_TRD;
                    end else begin
                        r_ma    <= ram_rdata;
                        r_state <= S_MUL;
                    end
                end
                S_OUTRD: r_state <= S_OUTLD;
                S_OUTLD: begin
                    r_oval  <= ram_rdata;
                    r_state <= S_OUTW;
                end
                S_OUTW: begin
                    if (o_out.ready) begin
                        if (r_cnt == 4'd15) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + 4'd1;
                            r_state <= S_OUTRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUTW);
    assign o_out.row   = r_cnt[3:2];
    assign o_out.col   = r_cnt[1:0];
    assign o_out.value = r_oval;
    assign o_out.last  = (r_cnt == 4'd15);
endmodule

// ===== rtl/emb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module emb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
